// ===== design/pfle_pkg.sv =====
package pfle_pkg;

	localparam int XW    = 7;
	localparam int YW    = 6;
	localparam int BW    = 8;
	localparam int KINDW = 3;
	localparam int MODEW = 2;
	localparam int CNTW  = 4;

	localparam logic [MODEW-1:0] MODE_SET    = 2'd0;
	localparam logic [MODEW-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODEW-1:0] MODE_INVERT = 2'd2;
	localparam logic [MODEW-1:0] MODE_KEEP   = 2'd3;

	typedef enum logic [KINDW-1:0] {
		REQ_PIXEL     = 3'd0,
		REQ_LINE      = 3'd1,
		REQ_READ_PIX  = 3'd2,
		REQ_READ_BYTE = 3'd3,
		REQ_SCROLL    = 3'd4,
		REQ_FILL      = 3'd5
	} req_kind_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LINE  = 6'b000100,
		ST_COPY  = 6'b001000,
		ST_SWEEP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_PIXEL,
		OP_PLOT,
		OP_READ_PIX,
		OP_READ_BYTE,
		OP_COPY,
		OP_WRITE
	} op_t;

	typedef struct packed {
		logic          valid;
		logic [XW-1:0] col;
		logic [YW-1:0] row;
	} point_t;

endpackage

// ===== design/pfle_if.sv =====
interface pfle_req_if;
	logic                         valid;
	logic                         ready;
	logic [pfle_pkg::KINDW-1:0]   req_type;
	logic [pfle_pkg::XW-1:0]      x_start;
	logic [pfle_pkg::YW-1:0]      y_start;
	logic [pfle_pkg::XW-1:0]      x_end;
	logic [pfle_pkg::YW-1:0]      y_end;
	logic [pfle_pkg::MODEW-1:0]   pixel_mode;
	logic [pfle_pkg::CNTW-1:0]    page_count;
	logic [pfle_pkg::BW-1:0]      fill_byte;

	modport source (
		output valid, req_type, x_start, y_start, x_end, y_end, pixel_mode, page_count,
			fill_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, x_start, y_start, x_end, y_end, pixel_mode, page_count,
			fill_byte,
		output ready
	);
endinterface

interface pfle_rsp_if;
	logic                    valid;
	logic                    ready;
	logic [pfle_pkg::BW-1:0] byte_value;
	logic                    pixel_value;

	modport source (
		output valid, byte_value, pixel_value,
		input  ready
	);
	modport sink (
		input  valid, byte_value, pixel_value,
		output ready
	);
endinterface

// ===== design/pfle_line.sv =====
module pfle_line (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [pfle_pkg::XW-1:0] x0,
	input  logic [pfle_pkg::YW-1:0] y0,
	input  logic [pfle_pkg::XW-1:0] x1,
	input  logic [pfle_pkg::YW-1:0] y1,
	output pfle_pkg::point_t        pt
);

	logic [6:0] ax0, ay0, ax1, ay1, adx, ady;
	logic [6:0] a0, a1, b0, b1, ma0, ma1, mb0, mb1;
	logic       steep, swap;

	logic              steep_q, up_q;
	logic [6:0]        maj_q, end_q, min_q, dx_q, dy_q;
	logic signed [9:0] err_q, err_n;
	logic signed [10:0] err2;
	logic              step;

	always_comb begin
		ax0   = 7'(x0);
		ay0   = 7'(y0);
		ax1   = 7'(x1);
		ay1   = 7'(y1);
		adx   = (ax1 >= ax0) ? ax1 - ax0 : ax0 - ax1;
		ady   = (ay1 >= ay0) ? ay1 - ay0 : ay0 - ay1;
		steep = ady > adx;
		a0    = steep ? ay0 : ax0;
		b0    = steep ? ax0 : ay0;
		a1    = steep ? ay1 : ax1;
		b1    = steep ? ax1 : ay1;
		swap  = a0 > a1;
		ma0   = swap ? a1 : a0;
		mb0   = swap ? b1 : b0;
		ma1   = swap ? a0 : a1;
		mb1   = swap ? b0 : b1;
	end

	always_comb begin
		pt.valid = maj_q < end_q;
		pt.col   = steep_q ? min_q : maj_q;
		pt.row   = steep_q ? maj_q[pfle_pkg::YW-1:0] : min_q[pfle_pkg::YW-1:0];
		err_n    = err_q + $signed({3'b000, dy_q});
		err2     = {err_n, 1'b0};
		step     = err2 >= $signed({4'b0000, dx_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maj_q <= '0;
			end_q <= '0;
		end else if (start) begin
			maj_q <= ma0;
			end_q <= ma1;
		end else if (pt.valid) begin
			maj_q <= maj_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			steep_q <= steep;
			min_q   <= mb0;
			up_q    <= mb0 < mb1;
			dx_q    <= ma1 - ma0;
			dy_q    <= (mb1 >= mb0) ? mb1 - mb0 : mb0 - mb1;
			err_q   <= '0;
		end else if (pt.valid) begin
			if (step) begin
				min_q <= up_q ? min_q + 7'd1 : min_q - 7'd1;
				err_q <= err_n - $signed({3'b000, dx_q});
			end else begin
				err_q <= err_n;
			end
		end
	end

endmodule

// ===== design/page_framebuffer_line_engine.sv =====
// Pixel op, read pixel and read byte: the result passes stage 1, then the output register.
// Line: one frame-store read-modify-write per cycle.
// Scroll and fill: one byte per cycle over the store.
// The single-port-write frame store sets these rates; results wait in an output register.
// After reset the store is cleared by a pass over every byte with ready low.
module page_framebuffer_line_engine #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	pfle_req_if.sink    req,
	pfle_rsp_if.source  rsp
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = $clog2(PAGES);
	localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
	localparam int BW = pfle_pkg::BW;

	function automatic logic [CW-1:0] col_wrap(input logic [pfle_pkg::XW-1:0] x);
		logic [10:0] r;
		r = 11'(x);
		if (r >= 11'(4 * COLUMNS)) r = r - 11'(4 * COLUMNS);
		if (r >= 11'(2 * COLUMNS)) r = r - 11'(2 * COLUMNS);
		if (r >= 11'(COLUMNS)) r = r - 11'(COLUMNS);
		return r[CW-1:0];
	endfunction

	function automatic logic [PW-1:0] page_wrap(input logic [2:0] p);
		logic [5:0] r;
		r = 6'(p);
		if (r >= 6'(2 * PAGES)) r = r - 6'(2 * PAGES);
		if (r >= 6'(PAGES)) r = r - 6'(PAGES);
		return r[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [pfle_pkg::XW-1:0] x,
			input logic [pfle_pkg::YW-1:0] y);
		return AW'(page_wrap(y[pfle_pkg::YW-1:3])) * COLS_A + AW'(col_wrap(x));
	endfunction

	pfle_pkg::state_t state_q;
	logic [AW-1:0]    ctr_q, off_q;
	logic [BW-1:0]    wconst_q;
	logic [pfle_pkg::MODEW-1:0] mode_q;
	logic [BW-1:0]    res_byte_q;
	logic             res_pix_q;
	logic             out_valid_q;
	logic [BW-1:0]    out_byte_q;
	logic             out_pix_q;

	logic [BW-1:0]    mem [DEPTH];
	logic [BW-1:0]    rdata_s1;
	logic             valid_s1;
	pfle_pkg::op_t    op_s1;
	logic [AW-1:0]    addr_s1;
	logic [2:0]       bit_s1;
	logic [pfle_pkg::MODEW-1:0] mode_s1;
	logic [BW-1:0]    data_s1;
	logic             wr_valid_q;
	logic [AW-1:0]    wr_addr_q;
	logic [BW-1:0]    wr_data_q;

	logic             accept, out_free, line_start;
	pfle_pkg::point_t line_pt;
	logic             iss_valid;
	pfle_pkg::op_t    iss_op;
	logic [AW-1:0]    iss_raddr, iss_waddr;
	logic [2:0]       iss_bit;
	logic [pfle_pkg::MODEW-1:0] iss_mode;

	logic [BW-1:0]    cur, mask, modv, wdata, s1_byte, done_byte;
	logic             we, s1_pix, s1_report, done_pix;

	assign req.ready   = state_q == pfle_pkg::ST_IDLE;
	assign accept      = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign line_start  = accept && (req.req_type == pfle_pkg::REQ_LINE);
	assign rsp.valid       = out_valid_q;
	assign rsp.byte_value  = out_byte_q;
	assign rsp.pixel_value = out_pix_q;

	pfle_line u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (line_start),
		.x0     (req.x_start),
		.y0     (req.y_start),
		.x1     (req.x_end),
		.y1     (req.y_end),
		.pt     (line_pt)
	);

	always_comb begin
		iss_valid = 1'b0;
		iss_op    = pfle_pkg::OP_WRITE;
		iss_raddr = ctr_q;
		iss_waddr = ctr_q;
		iss_bit   = 3'd0;
		iss_mode  = mode_q;
		case (state_q)
			pfle_pkg::ST_CLEAR, pfle_pkg::ST_SWEEP: begin
				iss_valid = 1'b1;
			end
			pfle_pkg::ST_IDLE: begin
				iss_raddr = addr_of(req.x_start, req.y_start);
				iss_waddr = iss_raddr;
				iss_bit   = req.y_start[2:0];
				iss_mode  = req.pixel_mode;
				case (pfle_pkg::req_kind_t'(req.req_type))
					pfle_pkg::REQ_PIXEL: begin
						iss_valid = accept;
						iss_op    = pfle_pkg::OP_PIXEL;
					end
					pfle_pkg::REQ_READ_PIX: begin
						iss_valid = accept;
						iss_op    = pfle_pkg::OP_READ_PIX;
					end
					pfle_pkg::REQ_READ_BYTE: begin
						iss_valid = accept;
						iss_op    = pfle_pkg::OP_READ_BYTE;
					end
					default: begin
						iss_valid = 1'b0;
					end
				endcase
			end
			pfle_pkg::ST_LINE: begin
				iss_valid = line_pt.valid;
				iss_op    = pfle_pkg::OP_PLOT;
				iss_raddr = addr_of(line_pt.col, line_pt.row);
				iss_waddr = iss_raddr;
				iss_bit   = line_pt.row[2:0];
			end
			pfle_pkg::ST_COPY: begin
				iss_valid = 1'b1;
				iss_op    = pfle_pkg::OP_COPY;
				iss_waddr = ctr_q - off_q;
			end
			default: begin
				iss_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		cur  = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_s1;
		mask = 8'b1 << bit_s1;
		case (mode_s1)
			pfle_pkg::MODE_SET:    modv = cur | mask;
			pfle_pkg::MODE_CLEAR:  modv = cur & ~mask;
			pfle_pkg::MODE_INVERT: modv = cur ^ mask;
			default:               modv = cur;
		endcase
		we        = 1'b0;
		wdata     = data_s1;
		s1_byte   = '0;
		s1_pix    = 1'b0;
		s1_report = 1'b0;
		case (op_s1)
			pfle_pkg::OP_PIXEL: begin
				we        = valid_s1;
				wdata     = modv;
				s1_byte   = modv;
				s1_pix    = modv[bit_s1];
				s1_report = valid_s1;
			end
			pfle_pkg::OP_PLOT: begin
				we    = valid_s1;
				wdata = modv;
			end
			pfle_pkg::OP_READ_PIX: begin
				s1_byte   = cur;
				s1_pix    = cur[bit_s1];
				s1_report = valid_s1;
			end
			pfle_pkg::OP_READ_BYTE: begin
				s1_byte   = cur;
				s1_report = valid_s1;
			end
			pfle_pkg::OP_COPY: begin
				we    = valid_s1;
				wdata = rdata_s1;
			end
			pfle_pkg::OP_WRITE: begin
				we = valid_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		done_byte = s1_report ? s1_byte : res_byte_q;
		done_pix  = s1_report ? s1_pix : res_pix_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr_s1] <= wdata;
		rdata_s1 <= mem[iss_raddr];
	end

	always_ff @(posedge clk) begin
		op_s1     <= iss_op;
		addr_s1   <= iss_waddr;
		bit_s1    <= iss_bit;
		mode_s1   <= iss_mode;
		data_s1   <= wconst_q;
		wr_addr_q <= addr_s1;
		wr_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			valid_s1   <= iss_valid;
			wr_valid_q <= we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfle_pkg::ST_CLEAR;
			ctr_q       <= '0;
			off_q       <= '0;
			wconst_q    <= '0;
			mode_q      <= pfle_pkg::MODE_SET;
			res_byte_q  <= '0;
			res_pix_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_pix_q   <= 1'b0;
		end else begin
			if (state_q == pfle_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pfle_pkg::ST_CLEAR: begin
					if (ctr_q == LAST) begin
						ctr_q   <= '0;
						state_q <= pfle_pkg::ST_IDLE;
					end else begin
						ctr_q <= ctr_q + AW'(1);
					end
				end
				pfle_pkg::ST_IDLE: begin
					if (accept) begin
						mode_q     <= req.pixel_mode;
						res_byte_q <= '0;
						res_pix_q  <= 1'b0;
						case (pfle_pkg::req_kind_t'(req.req_type))
							pfle_pkg::REQ_LINE: begin
								state_q <= pfle_pkg::ST_LINE;
							end
							pfle_pkg::REQ_SCROLL: begin
								if (req.page_count == '0) begin
									state_q <= pfle_pkg::ST_DONE;
								end else if ({1'b0, req.page_count} >= 5'(PAGES)) begin
									wconst_q <= '0;
									ctr_q    <= '0;
									state_q  <= pfle_pkg::ST_SWEEP;
								end else begin
									off_q   <= AW'(req.page_count) * COLS_A;
									ctr_q   <= AW'(req.page_count) * COLS_A;
									state_q <= pfle_pkg::ST_COPY;
								end
							end
							pfle_pkg::REQ_FILL: begin
								wconst_q <= req.fill_byte;
								ctr_q    <= '0;
								state_q  <= pfle_pkg::ST_SWEEP;
							end
							default: begin
								state_q <= pfle_pkg::ST_DONE;
							end
						endcase
					end
				end
				pfle_pkg::ST_LINE: begin
					if (!line_pt.valid) state_q <= pfle_pkg::ST_DONE;
				end
				pfle_pkg::ST_COPY: begin
					if (ctr_q == LAST) begin
						ctr_q    <= ctr_q - off_q + AW'(1);
						wconst_q <= '0;
						state_q  <= pfle_pkg::ST_SWEEP;
					end else begin
						ctr_q <= ctr_q + AW'(1);
					end
				end
				pfle_pkg::ST_SWEEP: begin
					ctr_q <= ctr_q + AW'(1);
					if (ctr_q == LAST) state_q <= pfle_pkg::ST_DONE;
				end
				pfle_pkg::ST_DONE: begin
					res_byte_q <= done_byte;
					res_pix_q  <= done_pix;
					if (out_free) begin
						out_byte_q  <= done_byte;
						out_pix_q   <= done_pix;
						state_q     <= pfle_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pfle_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
